// File: sv/leaky_lms_adaptive_fir_macros.svh
// ----------------------------------------------------------------------------
// Leaky LMS adaptive FIR assertion macros
// Shorthand for the concurrent checks in the top level.
// ----------------------------------------------------------------------------
`ifndef LEAKY_LMS_ADAPTIVE_FIR_MACROS_SVH
`define LEAKY_LMS_ADAPTIVE_FIR_MACROS_SVH

// checked only out of reset
`define LLMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define LLMS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: sv/llms_pkg.sv
// ----------------------------------------------------------------------------
// Leaky LMS adaptive FIR package
// Widths, reset values, register indexes and control types.
// ----------------------------------------------------------------------------
package llms_pkg;

  localparam int unsigned MAX_TAPS_DEF = 32;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned WEIGHT_W   = 32;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned NUM_TAPS_W = 6;

  localparam logic [NUM_TAPS_W-1:0] NUM_TAPS_RST = 6'd32;
  localparam logic [CFG_W-1:0]      STEP_RST     = 16'd328;
  localparam logic [CFG_W-1:0]      LEAK_RST     = 16'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_TAPS  = 2'd0,
    REG_STEP_SIZE = 2'd1,
    REG_LEAKAGE   = 2'd2
  } llms_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EST,
    ST_EST_DRAIN,
    ST_ERR,
    ST_COEF,
    ST_UPD,
    ST_UPD_DRAIN,
    ST_DONE
  } llms_state_e;

  typedef struct packed {
    llms_state_e state;
    logic        load_in;   // transaction accepted, clear accumulator
    logic        acc_en;    // estimate product valid
    logic        upd_pass;  // pipeline belongs to the weight update pass
    logic        ld_err;
    logic        ld_coef;
    logic        s1;        // memory read data valid
    logic        s2;        // products valid
  } llms_ctl_t;

endpackage

// File: sv/llms_ram.sv
// ----------------------------------------------------------------------------
// Leaky LMS state memory
// One write port, one registered read port; per-entry valid bits make
// unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module llms_ram #(
  parameter  int unsigned Width = 16,
  parameter  int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Depth-1:0] valid_q;
  logic [Width-1:0] rdata_q;
  logic             rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rvalid_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

// File: sv/llms_ctrl.sv
// ----------------------------------------------------------------------------
// Leaky LMS sequencer
// Walks the taps twice per transaction: once for the estimate, once for the
// weight update, and keeps the circular history position.
// ----------------------------------------------------------------------------
module llms_ctrl #(
  parameter  int unsigned MaxTaps = llms_pkg::MAX_TAPS_DEF,
  localparam int unsigned AddrW   = (MaxTaps > 1) ? $clog2(MaxTaps) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                out_free_i,
  output logic                out_load_o,
  input  logic [AddrW-1:0]    nm1_i,        // taps in use minus one
  output logic                hist_we_o,
  output logic [AddrW-1:0]    hist_waddr_o,
  output logic [AddrW-1:0]    hist_raddr_o,
  output logic [AddrW-1:0]    tap_raddr_o,
  output logic                tap_we_o,
  output logic [AddrW-1:0]    tap_waddr_o,
  output llms_pkg::llms_ctl_t ctl_o
);

  import llms_pkg::*;

  llms_state_e      state_q, state_d;
  logic [AddrW-1:0] cnt_q, cnt_d;
  logic [AddrW-1:0] hk_q, hk_d;
  logic [AddrW-1:0] wp_q, wp_d;
  logic [AddrW-1:0] wpc_q, wpc_d;
  logic [AddrW-1:0] ta1_q, ta2_q;
  logic             s1_q, s2_q;
  logic             issue;
  logic             accept;
  logic             upd_pass;
  logic [AddrW-1:0] wp_eff;
  logic [AddrW-1:0] hk_dec;

  // position left over from a larger tap count restarts at zero
  assign wp_eff = (wp_q > nm1_i) ? '0 : wp_q;
  assign hk_dec = (hk_q == '0) ? nm1_i : hk_q - AddrW'(1);
  assign accept = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    hk_d       = hk_q;
    wp_d       = wp_q;
    wpc_d      = wpc_q;
    issue      = 1'b0;
    out_load_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          wpc_d   = wp_eff;
          hk_d    = wp_eff;
          cnt_d   = '0;
          wp_d    = (wp_eff == nm1_i) ? '0 : wp_eff + AddrW'(1);
          state_d = ST_EST;
        end
      end
      ST_EST: begin
        issue = 1'b1;
        cnt_d = cnt_q + AddrW'(1);
        hk_d  = hk_dec;
        if (cnt_q == nm1_i) begin
          state_d = ST_EST_DRAIN;
        end
      end
      ST_EST_DRAIN: begin
        if (!s1_q) begin
          state_d = ST_ERR;
        end
      end
      ST_ERR: begin
        state_d = ST_COEF;
      end
      ST_COEF: begin
        cnt_d   = '0;
        hk_d    = wpc_q;
        state_d = ST_UPD;
      end
      ST_UPD: begin
        issue = 1'b1;
        cnt_d = cnt_q + AddrW'(1);
        hk_d  = hk_dec;
        if (cnt_q == nm1_i) begin
          state_d = ST_UPD_DRAIN;
        end
      end
      ST_UPD_DRAIN: begin
        if (!s1_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wp_q    <= '0;
      s1_q    <= 1'b0;
      s2_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      s1_q    <= issue;
      s2_q    <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    hk_q  <= hk_d;
    wpc_q <= wpc_d;
    ta1_q <= cnt_q;
    ta2_q <= ta1_q;
  end

  assign upd_pass = (state_q == ST_UPD) || (state_q == ST_UPD_DRAIN);

  assign in_ready_o   = (state_q == ST_IDLE);
  assign hist_we_o    = accept;
  assign hist_waddr_o = wp_eff;
  assign hist_raddr_o = hk_q;
  assign tap_raddr_o  = cnt_q;
  assign tap_we_o     = s2_q && upd_pass;
  assign tap_waddr_o  = ta2_q;

  always_comb begin
    ctl_o          = '0;
    ctl_o.state    = state_q;
    ctl_o.load_in  = accept;
    ctl_o.acc_en   = s2_q && ((state_q == ST_EST) || (state_q == ST_EST_DRAIN));
    ctl_o.upd_pass = upd_pass;
    ctl_o.ld_err   = (state_q == ST_ERR);
    ctl_o.ld_coef  = (state_q == ST_COEF);
    ctl_o.s1       = s1_q;
    ctl_o.s2       = s2_q;
  end

endmodule

// File: sv/llms_dp.sv
// ----------------------------------------------------------------------------
// Leaky LMS datapath
// Shared weight multiplier, accumulator, error and step terms, and the
// saturating weight update written back to the tap memory.
// ----------------------------------------------------------------------------
module llms_dp #(
  parameter  int unsigned MaxTaps = llms_pkg::MAX_TAPS_DEF,
  localparam int unsigned AddrW   = (MaxTaps > 1) ? $clog2(MaxTaps) : 1
) (
  input  logic                                   clk_i,
  input  llms_pkg::llms_ctl_t                    ctl_i,
  input  logic        [llms_pkg::CFG_W-1:0]      step_i,
  input  logic        [llms_pkg::CFG_W-1:0]      leak_i,
  input  logic signed [llms_pkg::SAMPLE_W-1:0]   desired_i,
  input  logic signed [llms_pkg::WEIGHT_W-1:0]   w_rdata_i,
  input  logic signed [llms_pkg::SAMPLE_W-1:0]   x_rdata_i,
  output logic        [llms_pkg::WEIGHT_W-1:0]   w_wdata_o,
  output logic        [llms_pkg::SAMPLE_W-1:0]   est_o,
  output logic        [llms_pkg::SAMPLE_W-1:0]   err_o,
  output logic                                   sat_o
);

  import llms_pkg::*;

  // weight * sample needs 48 bits; one more bit per doubling of the taps
  localparam int unsigned AccW = 48 + AddrW;
  localparam int unsigned EstW = AccW - 28;

  logic signed [15:0]     desired_q;
  logic signed [17:0]     opa;
  logic signed [49:0]     prod_a_d, prod_a_q;
  logic signed [48:0]     prod_b_d, prod_b_q;
  logic signed [31:0]     w_q;
  logic signed [AccW-1:0] acc_q;
  logic [EstW-1:0]        est_full;
  logic                   est_ovf;
  logic [15:0]            est_sat;
  logic [16:0]            err_full;
  logic                   err_ovf;
  logic [15:0]            err_sat;
  logic [15:0]            est_q, err_q;
  logic                   sat_q;
  logic [31:0]            sl_prod;
  logic [15:0]            sl_q;
  logic signed [32:0]     mu_err_q;
  logic [16:0]            factor_q;
  logic [33:0]            leaked;
  logic [30:0]            upd;
  logic [34:0]            base, sum;
  logic                   sum_ovf;

  // estimate pass: weight * sample; update pass: weight * leak factor
  assign opa = ctl_i.upd_pass ? $signed({1'b0, factor_q})
                              : $signed({{2{x_rdata_i[15]}}, x_rdata_i});
  assign prod_a_d = w_rdata_i * opa;
  assign prod_b_d = mu_err_q * x_rdata_i;

  always_ff @(posedge clk_i) begin
    prod_a_q <= prod_a_d;
    prod_b_q <= prod_b_d;
    w_q      <= w_rdata_i;
    if (ctl_i.load_in) begin
      desired_q <= desired_i;
      acc_q     <= '0;
    end else if (ctl_i.acc_en) begin
      acc_q <= acc_q + {{(AccW-48){prod_a_q[47]}}, prod_a_q[47:0]};
    end
  end

  // dropping the low bits is a floor shift
  assign est_full = acc_q[AccW-1:28];
  assign est_ovf  = !((&est_full[EstW-1:15]) || (~|est_full[EstW-1:15]));
  assign est_sat  = est_ovf ? (est_full[EstW-1] ? 16'h8000 : 16'h7fff) : est_full[15:0];
  assign err_full = {desired_q[15], desired_q} - {est_sat[15], est_sat};
  assign err_ovf  = err_full[16] != err_full[15];
  assign err_sat  = err_ovf ? (err_full[16] ? 16'h8000 : 16'h7fff) : err_full[15:0];
  assign sl_prod  = step_i * leak_i;

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_err) begin
      est_q <= est_sat;
      err_q <= err_sat;
      sat_q <= est_ovf || err_ovf;
      sl_q  <= sl_prod[31:16];
    end
    if (ctl_i.ld_coef) begin
      mu_err_q <= $signed({1'b0, step_i}) * $signed(err_q);
      factor_q <= 17'h10000 - {1'b0, sl_q};
    end
  end

  assign leaked  = prod_a_q[49:16];
  assign upd     = prod_b_q[48:18];
  assign base    = (leak_i != '0) ? {leaked[33], leaked} : {{3{w_q[31]}}, w_q};
  assign sum     = base + {{4{upd[30]}}, upd};
  assign sum_ovf = !((&sum[34:31]) || (~|sum[34:31]));

  assign w_wdata_o = sum_ovf ? (sum[34] ? 32'h8000_0000 : 32'h7fff_ffff) : sum[31:0];
  assign est_o     = est_q;
  assign err_o     = err_q;
  assign sat_o     = sat_q;

endmodule

// File: sv/leaky_lms_adaptive_fir.sv
// ----------------------------------------------------------------------------
// Leaky LMS adaptive FIR filter
// Fixed-point adaptive FIR with optional weight leakage.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis carries one reference sample and one desired sample
//   per transaction. Output stream m_axis returns the saturated estimate,
//   the error and a clip flag for each input transaction.
//   Config writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at once:
//   0 = tap count, 1 = step (zero writes ignored), 2 = leakage.
//   Write them only while no transaction is in flight.
// Timing:
//   Each transaction makes two passes over the N taps in use: one over the
//   tap memory for the estimate, one for the weight read-modify-write,
//   each pass one tap per cycle through the shared multiplier, followed
//   by a drain of the memory and product pipeline. The next transaction
//   is accepted once the update pass has drained and the result is loaded.
// Reset:
//   Weights and history read as zero, config returns to 32 taps, step 328,
//   no leakage. Reset is immediate, no clearing pass.
// Backpressure:
//   The result sits in an output register; one more transaction is worked
//   while it waits, then the block holds until m_axis_tready.
// ----------------------------------------------------------------------------
module leaky_lms_adaptive_fir #(
  parameter int unsigned MAX_TAPS = llms_pkg::MAX_TAPS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [llms_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [llms_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [31:0]                      s_axis_tdata,  // sample_in, desired
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [31:0]                      m_axis_tdata,  // estimate, error_out
  output logic [0:0]                       m_axis_tuser   // saturated
);

  import llms_pkg::*;

  localparam int unsigned AddrW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_TAPS + 1);
  localparam int unsigned NumW  = (CntW > NUM_TAPS_W) ? CntW : NUM_TAPS_W;

  logic [NUM_TAPS_W-1:0] num_taps_q;
  logic [CFG_W-1:0]      step_q, leak_q;
  logic [NumW-1:0]       ntaps_ext, n_eff;
  logic [AddrW-1:0]      nm1;

  logic                  out_free, out_load;
  logic                  hist_we, w_we;
  logic [AddrW-1:0]      hist_waddr, hist_raddr, w_raddr, w_waddr;
  logic [WEIGHT_W-1:0]   w_wdata, w_rdata;
  logic [SAMPLE_W-1:0]   x_rdata;
  logic [SAMPLE_W-1:0]   est, err;
  logic                  sat;
  llms_ctl_t             ctl;

  logic                  m_valid_q;
  logic [31:0]           m_data_q;
  logic                  m_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_taps_q <= NUM_TAPS_RST;
      step_q     <= STEP_RST;
      leak_q     <= LEAK_RST;
    end else if (cfg_we_i) begin
      case (llms_reg_e'(cfg_idx_i))
        REG_NUM_TAPS:  num_taps_q <= cfg_wdata_i[NUM_TAPS_W-1:0];
        REG_STEP_SIZE: begin
          if (cfg_wdata_i != '0) begin
            step_q <= cfg_wdata_i;
          end
        end
        REG_LEAKAGE:   leak_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // zero taps acts as one, too many as the built maximum
  assign ntaps_ext = NumW'(num_taps_q);
  assign n_eff = (num_taps_q == '0)              ? NumW'(1) :
                 (ntaps_ext > NumW'(MAX_TAPS))  ? NumW'(MAX_TAPS) : ntaps_ext;
  assign nm1   = AddrW'(n_eff - NumW'(1));

  assign out_free = !m_valid_q || m_axis_tready;

  llms_ctrl #(
    .MaxTaps (MAX_TAPS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .out_free_i   (out_free),
    .out_load_o   (out_load),
    .nm1_i        (nm1),
    .hist_we_o    (hist_we),
    .hist_waddr_o (hist_waddr),
    .hist_raddr_o (hist_raddr),
    .tap_raddr_o  (w_raddr),
    .tap_we_o     (w_we),
    .tap_waddr_o  (w_waddr),
    .ctl_o        (ctl)
  );

  llms_ram #(
    .Width (SAMPLE_W),
    .Depth (MAX_TAPS)
  ) u_hist_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (s_axis_tdata[15:0]),
    .raddr_i (hist_raddr),
    .rdata_o (x_rdata)
  );

  llms_ram #(
    .Width (WEIGHT_W),
    .Depth (MAX_TAPS)
  ) u_tap_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (w_wdata),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  llms_dp #(
    .MaxTaps (MAX_TAPS)
  ) u_dp (
    .clk_i     (clk_i),
    .ctl_i     (ctl),
    .step_i    (step_q),
    .leak_i    (leak_q),
    .desired_i (s_axis_tdata[31:16]),
    .w_rdata_i (w_rdata),
    .x_rdata_i (x_rdata),
    .w_wdata_o (w_wdata),
    .est_o     (est),
    .err_o     (err),
    .sat_o     (sat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {err, est};
      m_user_q <= sat;
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_user_q;

`include "leaky_lms_adaptive_fir_macros.svh"

  `LLMS_ASSERT(a_accept_idle, s_axis_tvalid && s_axis_tready |-> !ctl.s1 && !ctl.s2 && !w_we, "transaction accepted while taps in flight")
  `LLMS_ASSERT(a_wr_upd_only, w_we |-> ctl.upd_pass && !hist_we, "weight write outside update pass")
  `LLMS_ASSERT(a_out_from_done, $rose(m_axis_tvalid) |-> $past(ctl.state == ST_DONE), "result loaded before update finished")
  `LLMS_ASSERT_RST(a_rst_quiet, !rst_ni |=> !m_axis_tvalid && !w_we, "activity right after reset")

endmodule
